FILE: src/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
// Depends on nothing; every other file but bdq_ram imports it.
package bdq_pkg;

  // Default sizes of the store
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the request and result channels
  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CHECK     = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     found;
    logic [POS_W-1:0]         match_position;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
  } rsp_t;

endpackage

FILE: src/bdq_req_if.sv
// Request channel: one deque operation per transfer.
// Depends on bdq_pkg for field widths.
interface bdq_req_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

FILE: src/bdq_rsp_if.sv
// Result channel: one result per request.
// Depends on bdq_pkg for field widths.
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] removed_value;
  logic                     found;
  logic [POS_W-1:0]         match_position;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       entry_count;
  logic                     is_empty;

  modport source (output valid, removed_value, found, match_position, status,
                  entry_count, is_empty, input ready);
  modport sink   (input valid, removed_value, found, match_position, status,
                  entry_count, is_empty, output ready);
endinterface

FILE: src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/bdq_ctrl.sv
// Deque controller: front pointer, entry count, operation sequencer and
// search walk over the entry RAM. Depends on bdq_pkg.
module bdq_ctrl #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  bdq_pkg::req_t                         req,
  output logic                                  res_valid,
  output bdq_pkg::rsp_t                         res,
  input  logic                                  out_free,
  output logic                                  ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [VALUE_WIDTH-1:0]                ram_wdata,
  output logic                                  ram_re,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  input  logic [VALUE_WIDTH-1:0]                ram_rdata
);
  import bdq_pkg::*;

  localparam int SW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;
  localparam logic [SW:0]   DEPTH_W  = (SW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [SW-1:0] LAST_OFF = SW'(DEPTH - 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]        state, state_next;
  logic [SW-1:0]     front, front_next;
  logic [CW-1:0]     count, count_next;
  logic [SW-1:0]     idx, idx_next;
  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;

  logic              accept;
  logic [CW-1:0]     cnt_m1;
  logic [VALUE_WIDTH-1:0] val_cmp;
  logic              hit;
  logic              last;
  logic [SW-1:0]     idx_inc;

  // Ring slot of the entry at a given offset from the front
  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a,
                                             input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[SW-1:0];
  endfunction

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign cnt_m1    = count - CW'(1);
  assign val_cmp   = VALUE_WIDTH'($unsigned(val_r));
  assign hit       = (ram_rdata == val_cmp);
  assign last      = (idx == cnt_m1[SW-1:0]);
  assign idx_inc   = idx + SW'(1);

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = VALUE_WIDTH'($unsigned(val_r));
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_valid  = 1'b0;
    res        = '0;

    unique case (state)
      S_IDLE: begin
        // Issue the read a removal or a search needs
        if (accept) begin
          idx_next = '0;
          if (req.kind == KIND_REM_FRONT && count != '0) begin
            ram_re    = 1'b1;
            ram_raddr = front;
          end else if (req.kind == KIND_REM_BACK && count != '0) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(front, cnt_m1[SW-1:0]);
          end else if (req.kind == KIND_SEARCH && count != '0) begin
            ram_re    = 1'b1;
            ram_raddr = front;
          end
          if (req.kind == KIND_SEARCH && count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        // Apply the operation and post the result
        if (out_free) begin
          unique case (kind_r)
            KIND_INS_FRONT: begin
              if (count == DEPTH_C) begin
                res.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_add(front, LAST_OFF);
                front_next = wrap_add(front, LAST_OFF);
                count_next = count + CW'(1);
              end
            end
            KIND_INS_BACK: begin
              if (count == DEPTH_C) begin
                res.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_add(front, count[SW-1:0]);
                count_next = count + CW'(1);
              end
            end
            KIND_REM_FRONT: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                res.removed_value = DATA_W'(ram_rdata);
                front_next        = wrap_add(front, SW'(1));
                count_next        = cnt_m1;
              end
            end
            KIND_REM_BACK: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                res.removed_value = DATA_W'(ram_rdata);
                count_next        = cnt_m1;
              end
            end
            KIND_CHECK: begin
              res.found = (PCW'(pos_r) < PCW'(count));
            end
            default: begin
              // search of an empty store and unused codes change nothing
            end
          endcase
          res.entry_count = COUNT_W'(count_next);
          res.is_empty    = (count_next == '0);
          res_valid       = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_SCAN: begin
        // Compare one entry per cycle, fetch the next on a miss
        if (hit || last) begin
          if (out_free) begin
            res.found          = hit;
            res.match_position = hit ? POS_W'(idx) : '0;
            res.entry_count    = COUNT_W'(count);
            res.is_empty       = 1'b0;
            res_valid          = 1'b1;
            state_next         = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(front, idx_inc);
          idx_next  = idx_inc;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  // Hold the request and the walk offset
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      kind_r <= req.kind;
      val_r  <= $unsigned(req.value);
      pos_r  <= req.position;
    end
  end
endmodule

FILE: src/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: controller, entry RAM and
// result register. Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl, bdq_ram.
//
//   port  dir   carries
//   req   in    kind, value, position (one operation)
//   rsp   out   removed_value, found, match_position, status, entry_count, is_empty
//
// One request is in work at a time. Inserts, removals, position checks, unused
// codes and a search of an empty deque pass from acceptance through the EXEC state
// to the result register; a search walks from the front through the SCAN state,
// one RAM read per entry walked. The single RAM read port sets the search time.
// Synchronous reset empties the deque at once; RAM contents are not cleared.
// A result waits in the output register while the next request is accepted;
// a result stalls in the controller only while that register is still full.
module bounded_deque_with_search_top #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t                   req_pl;
  rsp_t                   res;
  logic                   res_valid;
  rsp_t                   out_reg;
  logic                   out_valid;
  logic                   out_free;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  assign req_pl.kind     = req.kind;
  assign req_pl.value    = req.value;
  assign req_pl.position = req.position;

  bdq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req       (req_pl),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bdq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: free when empty or being taken this cycle
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.removed_value  = out_reg.removed_value;
  assign rsp.found          = out_reg.found;
  assign rsp.match_position = out_reg.match_position;
  assign rsp.status         = out_reg.status;
  assign rsp.entry_count    = out_reg.entry_count;
  assign rsp.is_empty       = out_reg.is_empty;
endmodule
